// File: hdl/ctp_pkg.sv
`default_nettype none

package ctp_pkg;

    localparam int unsigned COORD_WIDTH = 24;

endpackage

`default_nettype wire

// File: hdl/ctp_sqrt.sv
`default_nettype none

// Pipelined integer square root, one result bit per stage, floor of the root.
module ctp_sqrt #(
    parameter int unsigned ROOT_W = 48
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [2*ROOT_W-1:0]   rad,
    output logic      [ROOT_W-1:0]     root
);

    localparam int unsigned RADW = 2 * ROOT_W;
    localparam int unsigned RMW  = ROOT_W + 2;

    logic [RMW-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RADW-1:0]   rad_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [RMW-1:0]    rem_in;
        logic [RMW-1:0]    cand;
        logic [RMW-1:0]    trial;
        logic [RMW-1:0]    rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic [RADW-1:0]   rad_in;
        logic [RADW-1:0]   rad_next;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        assign cand     = {rem_in[RMW-3:0], rad_in[RADW-1 -: 2]};
        assign trial    = {root_in, 2'b01};
        assign rad_next = {rad_in[RADW-3:0], 2'b00};

        always_comb
        begin
            if (cand >= trial)
            begin
                rem_next  = cand - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cand;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// File: hdl/ctp_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Needs num < den * 2**QUO_W.
module ctp_div #(
    parameter int unsigned NUM_W = 76,
    parameter int unsigned DEN_W = 51,
    parameter int unsigned QUO_W = 27
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    output logic      [QUO_W-1:0]   quo
);

    localparam int unsigned RMW = DEN_W + 1;

    logic [RMW-1:0]   rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic [RMW-1:0]   rem_in;
        logic [RMW-1:0]   cand;
        logic [RMW-1:0]   dext;
        logic [RMW-1:0]   rem_next;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] q_in;
        logic [QUO_W-1:0] q_next;
        logic [DEN_W-1:0] den_in;

        if (i == 0)
        begin : g_first
            assign rem_in = RMW'(num[NUM_W-1:QUO_W]);
            assign low_in = num[QUO_W-1:0];
            assign q_in   = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign cand = {rem_in[RMW-2:0], low_in[QUO_W-1]};
        assign dext = {1'b0, den_in};

        always_comb
        begin
            if (cand >= dext)
            begin
                rem_next = cand - dext;
                q_next   = {q_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = cand;
                q_next   = {q_in[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= {low_in[QUO_W-2:0], 1'b0};
                q_reg[i]   <= q_next;
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = q_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: hdl/circle_tangent_points.sv
`default_nettype none

// Tangent points from an external point to a circle. Each item carries a point, a circle
// center and a radius in raw fixed point; the result gives found and the two tangent
// points, rounded to nearest (ties away from zero) and saturated, all zero when the point
// lies inside the circle or on its center. The block is fully pipelined: it takes one
// item per cycle while the output does not stall, and it holds the square-root pipeline
// (2*COORD_WIDTH stages) and the dividers (COORD_WIDTH+3 stages). A stall on the output
// freezes the whole pipeline.
module circle_tangent_points #(
    parameter int unsigned COORD_WIDTH = ctp_pkg::COORD_WIDTH
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // point_x, point_y, center_x, center_y, radius
    input  wire logic [((5*COORD_WIDTH-1+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // first_x, first_y, second_x, second_y
    output logic      [((4*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // found
    output logic                                         m_axis_tuser
);

    localparam int unsigned W       = COORD_WIDTH;
    localparam int unsigned ABS_W   = W + 1;
    localparam int unsigned SQ_W    = 2 * W + 2;
    localparam int unsigned R2_W    = 2 * W - 2;
    localparam int unsigned LH      = W - 1;
    localparam int unsigned DH      = W + 1;
    localparam int unsigned RADIC_W = 4 * W;
    localparam int unsigned ROOT_W  = 2 * W;
    localparam int unsigned PA_W    = R2_W + ABS_W;
    localparam int unsigned PB_W    = ROOT_W + ABS_W;
    localparam int unsigned SUM_W   = 3 * W + 3;
    localparam int unsigned MAG_W   = 3 * W + 2;
    localparam int unsigned NUM_W   = 3 * W + 4;
    localparam int unsigned DEN_W   = 2 * W + 3;
    localparam int unsigned QUO_W   = W + 3;
    localparam int unsigned OFF_W   = W + 4;
    localparam int unsigned OUT_W   = 4 * W;
    localparam int unsigned OUT_PAD = ((OUT_W + 7) / 8) * 8;

    localparam int unsigned T       = 6 + ROOT_W;
    localparam int unsigned U       = T + 6 + QUO_W;
    localparam int unsigned LAT     = U + 3;

    localparam int unsigned SO_NY   = 2 * ABS_W;
    localparam int unsigned SO_NX   = SO_NY + 1;
    localparam int unsigned SO_CY   = SO_NY + 2;
    localparam int unsigned SO_CX   = SO_CY + W;
    localparam int unsigned SIDE_W  = SO_CX + W;
    localparam int unsigned MV_W    = R2_W + SQ_W + 1;

    logic en;
    logic vld_reg [LAT];

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // s1: differences and magnitudes
    logic [W-1:0]      px_in, py_in, cx_in, cy_in;
    logic [W-2:0]      r_in;
    logic signed [W:0] dx_next, dy_next;
    logic [SIDE_W-1:0] side_next;
    logic [SIDE_W-1:0] side_reg [U+1];
    logic [W-2:0]      r1_reg;

    assign px_in = s_axis_tdata[W-1:0];
    assign py_in = s_axis_tdata[2*W-1:W];
    assign cx_in = s_axis_tdata[3*W-1:2*W];
    assign cy_in = s_axis_tdata[4*W-1:3*W];
    assign r_in  = s_axis_tdata[5*W-2:4*W];

    always_comb
    begin
        dx_next   = $signed({px_in[W-1], px_in}) - $signed({cx_in[W-1], cx_in});
        dy_next   = $signed({py_in[W-1], py_in}) - $signed({cy_in[W-1], cy_in});
        side_next = {cx_in, cy_in, dx_next[W], dy_next[W],
                     dx_next[W] ? $unsigned(-dx_next) : $unsigned(dx_next),
                     dy_next[W] ? $unsigned(-dy_next) : $unsigned(dy_next)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= U; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            r1_reg <= r_in;
        end
    end

    // s2..s6: squares, distance, radicand
    logic [ABS_W-1:0]   ay1;
    logic [SQ_W-1:0]    sqx2_reg, sqy2_reg, d23_reg, diff4_reg;
    logic [R2_W-1:0]    r22_reg, r23_reg;
    logic [MV_W-1:0]    mv_reg [U-1];
    logic [R2_W-1:0]    r2_4;
    logic [2*W-1:0]     pp5_reg [4];
    logic [RADIC_W-1:0] rad6_reg;

    assign ay1  = side_reg[0][ABS_W-1:0];
    assign r2_4 = mv_reg[0][R2_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx2_reg <= SQ_W'(side_reg[0][2*ABS_W-1:ABS_W] * side_reg[0][2*ABS_W-1:ABS_W]);
            sqy2_reg <= SQ_W'(ay1 * ay1);
            r22_reg  <= R2_W'(r1_reg * r1_reg);
            d23_reg  <= sqx2_reg + sqy2_reg;
            r23_reg  <= r22_reg;
            diff4_reg <= d23_reg - SQ_W'(r23_reg);
            mv_reg[0] <= {(d23_reg != '0) && (d23_reg >= SQ_W'(r23_reg)), d23_reg, r23_reg};
            for (int k = 1; k < U - 1; k++)
            begin
                mv_reg[k] <= mv_reg[k-1];
            end
            pp5_reg[0] <= (2*W)'(r2_4[LH-1:0] * diff4_reg[DH-1:0]);
            pp5_reg[1] <= (2*W)'(r2_4[LH-1:0] * diff4_reg[SQ_W-1:DH]);
            pp5_reg[2] <= (2*W)'(r2_4[R2_W-1:LH] * diff4_reg[DH-1:0]);
            pp5_reg[3] <= (2*W)'(r2_4[R2_W-1:LH] * diff4_reg[SQ_W-1:DH]);
            rad6_reg <= RADIC_W'(pp5_reg[0])
                      + RADIC_W'({pp5_reg[1], {DH{1'b0}}})
                      + RADIC_W'({pp5_reg[2], {LH{1'b0}}})
                      + RADIC_W'({pp5_reg[3], {(LH+DH){1'b0}}});
        end
    end

    // square root of r2 * (d2 - r2)
    logic [ROOT_W-1:0] root;

    ctp_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad6_reg),
        .root (root)
    );

    // m1..m6: products, signed combinations, rounding numerators
    logic [SIDE_W-1:0]          side_m;
    logic [R2_W-1:0]            r2_m;
    logic [2*W-1:0]             pa_reg [4];
    logic [2*W:0]               pb_reg [4];
    logic [PA_W-1:0]            ax_reg, ay_reg;
    logic [PB_W-1:0]            bx_reg, by_reg;
    logic                       nx_m2, ny_m2;
    logic signed [SUM_W-1:0]    tax_reg, tay_reg, tbx_reg, tby_reg;
    logic signed [SUM_W-1:0]    s_reg [4];
    logic [MAG_W-1:0]           mag_reg [4];
    logic                       neg_reg [4][QUO_W+2];
    logic [NUM_W-1:0]           num_reg [4];
    logic [DEN_W-1:0]           den_reg;
    logic [SQ_W-1:0]            d2_m5;

    assign side_m = side_reg[T-1];
    assign r2_m   = mv_reg[T-4][R2_W-1:0];
    assign nx_m2  = side_reg[T+1][SO_NX];
    assign ny_m2  = side_reg[T+1][SO_NY];
    assign d2_m5  = mv_reg[T+1][R2_W+SQ_W-1:R2_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= (2*W)'(r2_m[LH-1:0]    * side_m[2*ABS_W-1:ABS_W]);
            pa_reg[1] <= (2*W)'(r2_m[R2_W-1:LH] * side_m[2*ABS_W-1:ABS_W]);
            pa_reg[2] <= (2*W)'(r2_m[LH-1:0]    * side_m[ABS_W-1:0]);
            pa_reg[3] <= (2*W)'(r2_m[R2_W-1:LH] * side_m[ABS_W-1:0]);
            pb_reg[0] <= (2*W+1)'(root[W-1:0]        * side_m[2*ABS_W-1:ABS_W]);
            pb_reg[1] <= (2*W+1)'(root[ROOT_W-1:W]   * side_m[2*ABS_W-1:ABS_W]);
            pb_reg[2] <= (2*W+1)'(root[W-1:0]        * side_m[ABS_W-1:0]);
            pb_reg[3] <= (2*W+1)'(root[ROOT_W-1:W]   * side_m[ABS_W-1:0]);

            ax_reg <= PA_W'({pa_reg[1], {LH{1'b0}}}) + PA_W'(pa_reg[0]);
            ay_reg <= PA_W'({pa_reg[3], {LH{1'b0}}}) + PA_W'(pa_reg[2]);
            bx_reg <= PB_W'({pb_reg[1], {W{1'b0}}}) + PB_W'(pb_reg[0]);
            by_reg <= PB_W'({pb_reg[3], {W{1'b0}}}) + PB_W'(pb_reg[2]);

            tax_reg <= nx_m2 ? -$signed(SUM_W'(ax_reg)) : $signed(SUM_W'(ax_reg));
            tay_reg <= ny_m2 ? -$signed(SUM_W'(ay_reg)) : $signed(SUM_W'(ay_reg));
            tbx_reg <= nx_m2 ? -$signed(SUM_W'(bx_reg)) : $signed(SUM_W'(bx_reg));
            tby_reg <= ny_m2 ? -$signed(SUM_W'(by_reg)) : $signed(SUM_W'(by_reg));

            s_reg[0] <= tax_reg - tby_reg;
            s_reg[1] <= tay_reg + tbx_reg;
            s_reg[2] <= tax_reg + tby_reg;
            s_reg[3] <= tay_reg - tbx_reg;

            for (int k = 0; k < 4; k++)
            begin
                neg_reg[k][0] <= s_reg[k][SUM_W-1];
                mag_reg[k]    <= s_reg[k][SUM_W-1] ? MAG_W'(-s_reg[k]) : MAG_W'(s_reg[k]);
                num_reg[k]    <= NUM_W'({mag_reg[k], 1'b0}) + NUM_W'(d2_m5);
                for (int j = 1; j < QUO_W + 2; j++)
                begin
                    neg_reg[k][j] <= neg_reg[k][j-1];
                end
            end
            den_reg <= {d2_m5, 1'b0};
        end
    end

    // dividers and final add, saturation
    logic [QUO_W-1:0]        quo [4];
    logic signed [OFF_W-1:0] off_reg [4];
    logic signed [OFF_W-1:0] sum_reg [4];
    logic [W-1:0]            res_reg [4];
    logic                    found_reg;
    logic [W-1:0]            c_f1 [4];
    logic                    found_f2;

    for (genvar g = 0; g < 4; g++)
    begin : g_div
        ctp_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .QUO_W (QUO_W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[g]),
            .den (den_reg),
            .quo (quo[g])
        );

        assign c_f1[g] = (g % 2 == 0) ? side_reg[U][SO_CX+W-1:SO_CX]
                                      : side_reg[U][SO_CY+W-1:SO_CY];
    end

    assign found_f2 = mv_reg[U-2][MV_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                off_reg[k] <= neg_reg[k][QUO_W+1] ? -$signed(OFF_W'(quo[k]))
                                                  : $signed(OFF_W'(quo[k]));
                sum_reg[k] <= off_reg[k] + $signed({{(OFF_W-W){c_f1[k][W-1]}}, c_f1[k]});
                if (!found_f2)
                begin
                    res_reg[k] <= '0;
                end
                else if ((&sum_reg[k][OFF_W-1:W-1]) || !(|sum_reg[k][OFF_W-1:W-1]))
                begin
                    res_reg[k] <= sum_reg[k][W-1:0];
                end
                else if (sum_reg[k][OFF_W-1])
                begin
                    res_reg[k] <= {1'b1, {(W-1){1'b0}}};
                end
                else
                begin
                    res_reg[k] <= {1'b0, {(W-1){1'b1}}};
                end
            end
            found_reg <= found_f2;
        end
    end

    assign m_axis_tdata = OUT_PAD'({res_reg[3], res_reg[2], res_reg[1], res_reg[0]});
    assign m_axis_tuser = found_reg;

endmodule

`default_nettype wire
